// ===== sv/ofcm_pkg.sv =====
// ----------------------------------------------------------------------------
// ofcm_pkg: shared types and constants of the face culling mesher
// Field widths, face codes, corner table, shade levels and sequencer states.
// ----------------------------------------------------------------------------
package ofcm_pkg;

  localparam int MAP_SIZE_DEF   = 128;
  localparam int CELL_SPAN_DEF  = 16;
  localparam int BOX_HEIGHT_DEF = 4;

  localparam int CELL_W  = 7;
  localparam int ALPHA_W = 8;
  localparam int BASE_W  = 16;
  localparam int POS_W   = 12;
  localparam int POSZ_W  = 17;
  localparam int FACE_W  = 3;
  localparam int SHADE_W = 8;

  localparam logic [ALPHA_W-1:0] ALPHA_MASK = 8'hFF;
  localparam logic [ALPHA_W-1:0] ALPHA_MIN  = 8'd1;

  // unorm8 of 0.85, 0.8 and 0.9, rounded to nearest
  localparam logic [SHADE_W-1:0] SHADE_X = 8'd217;
  localparam logic [SHADE_W-1:0] SHADE_Y = 8'd204;
  localparam logic [SHADE_W-1:0] SHADE_Z = 8'd230;

  // six vertices per face, indices 0..5
  localparam logic [2:0] VTX_LAST = 3'd5;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_EXPAND = 1'b1
  } kind_e;

  typedef enum logic [FACE_W-1:0] {
    FACE_WEST   = 3'd0,
    FACE_EAST   = 3'd1,
    FACE_SOUTH  = 3'd2,
    FACE_NORTH  = 3'd3,
    FACE_BOTTOM = 3'd4,
    FACE_TOP    = 3'd5
  } face_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_C,
    ST_RD_W,
    ST_RD_E,
    ST_EMIT
  } st_e;

  // corner offsets {x, y, z} of corner c of face f
  function automatic logic [2:0] corner_off(face_e f, logic [1:0] c);
    logic [2:0] r;
    r = 3'b000;
    case (f)
      FACE_WEST: begin
        case (c)
          2'd0:    r = 3'b010;
          2'd1:    r = 3'b000;
          2'd2:    r = 3'b001;
          default: r = 3'b011;
        endcase
      end
      FACE_EAST: begin
        case (c)
          2'd0:    r = 3'b100;
          2'd1:    r = 3'b110;
          2'd2:    r = 3'b111;
          default: r = 3'b101;
        endcase
      end
      FACE_SOUTH: begin
        case (c)
          2'd0:    r = 3'b000;
          2'd1:    r = 3'b100;
          2'd2:    r = 3'b101;
          default: r = 3'b001;
        endcase
      end
      FACE_NORTH: begin
        case (c)
          2'd0:    r = 3'b110;
          2'd1:    r = 3'b010;
          2'd2:    r = 3'b011;
          default: r = 3'b111;
        endcase
      end
      FACE_BOTTOM: begin
        case (c)
          2'd0:    r = 3'b100;
          2'd1:    r = 3'b000;
          2'd2:    r = 3'b010;
          default: r = 3'b110;
        endcase
      end
      FACE_TOP: begin
        case (c)
          2'd0:    r = 3'b001;
          2'd1:    r = 3'b101;
          2'd2:    r = 3'b111;
          default: r = 3'b011;
        endcase
      end
      default: r = 3'b000;
    endcase
    return r;
  endfunction

  // two triangles per quad: corners 0,1,2,2,3,0
  function automatic logic [1:0] vtx_corner(logic [2:0] v);
    logic [1:0] r;
    case (v)
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd2;
      3'd4:    r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [SHADE_W-1:0] face_shade(face_e f);
    logic [SHADE_W-1:0] r;
    case (f)
      FACE_WEST, FACE_EAST:   r = SHADE_X;
      FACE_SOUTH, FACE_NORTH: r = SHADE_Y;
      default:                r = SHADE_Z;
    endcase
    return r;
  endfunction

  // lowest kept face at or above start; top is always kept
  function automatic face_e pick_face(logic [5:0] keep, logic [2:0] start);
    face_e r;
    r = FACE_TOP;
    for (int i = 5; i >= 0; i--) begin
      if (keep[i] && (i >= int'(start))) r = face_e'(3'(i));
    end
    return r;
  endfunction

endpackage

// ===== sv/ofcm_mem.sv =====
// ----------------------------------------------------------------------------
// ofcm_mem: occupancy bitmap storage
// One row per map column, bit-masked write port, registered read port.
// ----------------------------------------------------------------------------
module ofcm_mem #(
  parameter int MAP_SIZE = 128,
  localparam int AW = $clog2(MAP_SIZE)
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  logic [MAP_SIZE-1:0] wr_mask_i,
  input  logic [MAP_SIZE-1:0] wr_data_i,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  output logic [MAP_SIZE-1:0] rd_data_o
);

  logic [MAP_SIZE-1:0] mem_q [MAP_SIZE];
  logic [MAP_SIZE-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      for (int i = 0; i < MAP_SIZE; i++) begin
        if (wr_mask_i[i]) mem_q[wr_addr_i][i] <= wr_data_i[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/ofcm_seq.sv =====
// ----------------------------------------------------------------------------
// ofcm_seq: item sequencer and vertex generator
// Clears the map, applies writes, reads the three rows around an expanded cell,
// then walks its kept faces into the output reg one vertex per unstalled cycle.
// ----------------------------------------------------------------------------
module ofcm_seq #(
  parameter int MAP_SIZE   = 128,
  parameter int CELL_SPAN  = 16,
  parameter int BOX_HEIGHT = 4,
  localparam int AW = $clog2(MAP_SIZE)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic [ofcm_pkg::CELL_W-1:0]         cell_x_i,
  input  logic [ofcm_pkg::CELL_W-1:0]         cell_y_i,
  input  logic [ofcm_pkg::ALPHA_W-1:0]        texel_alpha_i,
  input  logic signed [ofcm_pkg::BASE_W-1:0]  base_height_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ofcm_pkg::POS_W-1:0]          pos_x_o,
  output logic [ofcm_pkg::POS_W-1:0]          pos_y_o,
  output logic signed [ofcm_pkg::POSZ_W-1:0]  pos_z_o,
  output logic [ofcm_pkg::FACE_W-1:0]         face_index_o,
  output logic [ofcm_pkg::SHADE_W-1:0]        shade_level_o,
  output logic                                last_vertex_o,
  output logic                                mem_wr_en_o,
  output logic [AW-1:0]                       mem_wr_addr_o,
  output logic [MAP_SIZE-1:0]                 mem_wr_mask_o,
  output logic [MAP_SIZE-1:0]                 mem_wr_data_o,
  output logic                                mem_rd_en_o,
  output logic [AW-1:0]                       mem_rd_addr_o,
  input  logic [MAP_SIZE-1:0]                 mem_rd_data_i
);

  import ofcm_pkg::*;

  localparam logic [AW-1:0] LAST_IDX = AW'(MAP_SIZE - 1);

  st_e             state_q, state_d;
  logic [AW-1:0]   cx_q, cx_d, cy_q, cy_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic            center_q, center_d, south_q, south_d;
  logic            north_q, north_d, west_q, west_d;
  logic [5:0]      keep_q, keep_d;
  face_e           face_q, face_d;
  logic [2:0]      vtx_q, vtx_d;

  logic                     out_valid_q, out_valid_d;
  logic [POS_W-1:0]         pos_x_q, pos_y_q;
  logic signed [POSZ_W-1:0] pos_z_q;
  logic [FACE_W-1:0]        face_out_q;
  logic [SHADE_W-1:0]       shade_q;
  logic                     last_q;

  logic                     in_map, out_load, emit_vtx, vtx_last;
  logic                     has_w, has_e, has_s, has_n, east_occ;
  logic [AW-1:0]            cx_in, cy_in, ny_lo, ny_hi;
  logic [5:0]               keep_new;
  logic [2:0]               cur_off;
  logic [POS_W-1:0]         vtx_x, vtx_y;
  logic signed [POSZ_W-1:0] vtx_z;

  assign in_map   = (32'(cell_x_i) < MAP_SIZE) && (32'(cell_y_i) < MAP_SIZE);
  assign cx_in    = AW'(cell_x_i);
  assign cy_in    = AW'(cell_y_i);
  assign has_w    = (cx_q != '0);
  assign has_e    = (cx_q != LAST_IDX);
  assign has_s    = (cy_q != '0);
  assign has_n    = (cy_q != LAST_IDX);
  // neighbour bit indices, held in range at the map edge
  assign ny_lo    = has_s ? cy_q - AW'(1) : cy_q;
  assign ny_hi    = has_n ? cy_q + AW'(1) : cy_q;
  assign east_occ = has_e && mem_rd_data_i[cy_q];
  assign keep_new = {2'b11, ~north_q, ~south_q, ~east_occ, ~west_q};

  assign out_load = !out_valid_q || !out_stall_i;
  assign vtx_last = (face_q == FACE_TOP) && (vtx_q == VTX_LAST);
  assign cur_off  = corner_off(face_q, vtx_corner(vtx_q));
  assign vtx_x    = POS_W'((32'(cx_q) + 32'(cur_off[2])) * CELL_SPAN);
  assign vtx_y    = POS_W'((32'(cy_q) + 32'(cur_off[1])) * CELL_SPAN);
  assign vtx_z    = {base_height_i[BASE_W-1], base_height_i}
                  + (cur_off[0] ? POSZ_W'(BOX_HEIGHT) : '0);

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d       = state_q;
    cx_d          = cx_q;
    cy_d          = cy_q;
    clr_d         = clr_q;
    center_d      = center_q;
    south_d       = south_q;
    north_d       = north_q;
    west_d        = west_q;
    keep_d        = keep_q;
    face_d        = face_q;
    vtx_d         = vtx_q;
    out_valid_d   = out_valid_q && out_stall_i;
    emit_vtx      = 1'b0;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = clr_q;
    mem_wr_mask_o = '1;
    mem_wr_data_o = '0;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = cx_q;
    case (state_q)
      ST_CLEAR: begin
        mem_wr_en_o = 1'b1;
        clr_d       = clr_q + AW'(1);
        if (clr_q == LAST_IDX) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i && in_map) begin
          cx_d = cx_in;
          cy_d = cy_in;
          if (kind_i == KIND_WRITE) begin
            mem_wr_en_o   = 1'b1;
            mem_wr_addr_o = cx_in;
            mem_wr_mask_o = MAP_SIZE'(1) << cy_in;
            mem_wr_data_o = {MAP_SIZE{(texel_alpha_i & ALPHA_MASK) > ALPHA_MIN}};
          end else begin
            mem_rd_en_o   = 1'b1;
            mem_rd_addr_o = cx_in;
            state_d       = ST_RD_C;
          end
        end
      end
      ST_RD_C: begin
        // own column: center, south and north bits
        center_d      = mem_rd_data_i[cy_q];
        south_d       = has_s && mem_rd_data_i[ny_lo];
        north_d       = has_n && mem_rd_data_i[ny_hi];
        mem_rd_en_o   = 1'b1;
        mem_rd_addr_o = has_w ? cx_q - AW'(1) : cx_q;
        state_d       = ST_RD_W;
      end
      ST_RD_W: begin
        west_d        = has_w && mem_rd_data_i[cy_q];
        mem_rd_en_o   = 1'b1;
        mem_rd_addr_o = has_e ? cx_q + AW'(1) : cx_q;
        state_d       = ST_RD_E;
      end
      ST_RD_E: begin
        if (!center_q) begin
          state_d = ST_IDLE;
        end else begin
          keep_d  = keep_new;
          face_d  = pick_face(keep_new, 3'd0);
          vtx_d   = 3'd0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          emit_vtx    = 1'b1;
          out_valid_d = 1'b1;
          if (vtx_q == VTX_LAST) begin
            vtx_d = 3'd0;
            if (face_q == FACE_TOP) state_d = ST_IDLE;
            else face_d = pick_face(keep_q, 3'(face_q) + 3'd1);
          end else begin
            vtx_d = vtx_q + 3'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    center_q <= center_d;
    south_q  <= south_d;
    north_q  <= north_d;
    west_q   <= west_d;
    keep_q   <= keep_d;
    face_q   <= face_d;
    vtx_q    <= vtx_d;
    if (emit_vtx) begin
      pos_x_q    <= vtx_x;
      pos_y_q    <= vtx_y;
      pos_z_q    <= vtx_z;
      face_out_q <= 3'(face_q);
      shade_q    <= face_shade(face_q);
      last_q     <= vtx_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pos_x_o       = pos_x_q;
  assign pos_y_o       = pos_y_q;
  assign pos_z_o       = pos_z_q;
  assign face_index_o  = face_out_q;
  assign shade_level_o = shade_q;
  assign last_vertex_o = last_q;

  a_rw_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_wr_en_o && mem_rd_en_o))
    else $error("map read and write in the same cycle");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_load && vtx_last) |=> (state_q == ST_IDLE))
    else $error("sequencer did not return to idle after last vertex");

  a_face_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> keep_q[face_q])
    else $error("emitting a culled face");

  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("output valid raised outside face walk");

endmodule

// ===== sv/occupancy_face_culling_mesher_top.sv =====
// ----------------------------------------------------------------------------
// occupancy_face_culling_mesher_top: occupancy bitmap box mesher
// Write item: applied to the map on transfer; input stays ready. Expand item:
// 3 map row reads through states RD_C, RD_W and RD_E, then the EMIT state
// registers one vertex per cycle while the output is not stalled; N vertices
// per item (12..36), none if the cell is empty; input stalled until idle.
// Reset: base_height 0; map cleared one row a cycle with input stalled.
// ----------------------------------------------------------------------------
module occupancy_face_culling_mesher_top #(
  parameter int MAP_SIZE   = ofcm_pkg::MAP_SIZE_DEF,
  parameter int CELL_SPAN  = ofcm_pkg::CELL_SPAN_DEF,
  parameter int BOX_HEIGHT = ofcm_pkg::BOX_HEIGHT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ofcm_pkg::BASE_W-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic [ofcm_pkg::CELL_W-1:0]         cell_x_i,
  input  logic [ofcm_pkg::CELL_W-1:0]         cell_y_i,
  input  logic [ofcm_pkg::ALPHA_W-1:0]        texel_alpha_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ofcm_pkg::POS_W-1:0]          pos_x_o,
  output logic [ofcm_pkg::POS_W-1:0]          pos_y_o,
  output logic signed [ofcm_pkg::POSZ_W-1:0]  pos_z_o,
  output logic [ofcm_pkg::FACE_W-1:0]         face_index_o,
  output logic [ofcm_pkg::SHADE_W-1:0]        shade_level_o,
  output logic                                last_vertex_o
);

  import ofcm_pkg::*;

  localparam int AW = $clog2(MAP_SIZE);

  logic signed [BASE_W-1:0] base_height_q;
  logic                     wr_en, rd_en;
  logic [AW-1:0]            wr_addr, rd_addr;
  logic [MAP_SIZE-1:0]      wr_mask, wr_data, rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_height_q <= '0;
    end else if (cfg_we_i) begin
      base_height_q <= cfg_wdata_i;
    end
  end

  ofcm_seq #(
    .MAP_SIZE   (MAP_SIZE),
    .CELL_SPAN  (CELL_SPAN),
    .BOX_HEIGHT (BOX_HEIGHT)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .cell_x_i      (cell_x_i),
    .cell_y_i      (cell_y_i),
    .texel_alpha_i (texel_alpha_i),
    .base_height_i (base_height_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .pos_z_o       (pos_z_o),
    .face_index_o  (face_index_o),
    .shade_level_o (shade_level_o),
    .last_vertex_o (last_vertex_o),
    .mem_wr_en_o   (wr_en),
    .mem_wr_addr_o (wr_addr),
    .mem_wr_mask_o (wr_mask),
    .mem_wr_data_o (wr_data),
    .mem_rd_en_o   (rd_en),
    .mem_rd_addr_o (rd_addr),
    .mem_rd_data_i (rd_data)
  );

  ofcm_mem #(
    .MAP_SIZE (MAP_SIZE)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_mask_i (wr_mask),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

endmodule

// ===== tb/occupancy_face_culling_mesher_top_test.sv =====
// ----------------------------------------------------------------------------
// occupancy_face_culling_mesher_top_test: self-checking bench for the mesher
// Directed cell writes and expands at the map edges and around a fully enclosed
// cell, then random write/expand traffic clustered in small windows so that
// neighbor culling is exercised. The bench keeps its own occupancy map and
// box geometry and checks every vertex in order. Base height is changed
// between phases, and idling on both channels is varied.
// ----------------------------------------------------------------------------
module occupancy_face_culling_mesher_top_test;
  import ofcm_pkg::*;

  localparam int MAP_N       = MAP_SIZE_DEF;
  localparam int SPAN        = CELL_SPAN_DEF;
  localparam int BOX_H       = BOX_HEIGHT_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 8;
  localparam int REPORT_MAX  = 10;

  // {x,y,z} offsets, face f corner c at bits (f*4+c)*3, top face first here
  localparam logic [71:0] BOX_CORNERS = {
    3'b011, 3'b111, 3'b101, 3'b001,   // top
    3'b110, 3'b010, 3'b000, 3'b100,   // bottom
    3'b111, 3'b011, 3'b010, 3'b110,   // north
    3'b001, 3'b101, 3'b100, 3'b000,   // south
    3'b101, 3'b111, 3'b110, 3'b100,   // east
    3'b011, 3'b001, 3'b000, 3'b010    // west
  };
  // two triangles per quad: corners 0,1,2,2,3,0
  localparam logic [11:0] TRI_CORNERS = {2'd0, 2'd3, 2'd2, 2'd2, 2'd1, 2'd0};

  typedef struct packed {
    kind_e              kind;
    logic [CELL_W-1:0]  cx;
    logic [CELL_W-1:0]  cy;
    logic [ALPHA_W-1:0] alpha;
  } cell_req_t;

  typedef struct packed {
    logic [POS_W-1:0]         pos_x;
    logic [POS_W-1:0]         pos_y;
    logic signed [POSZ_W-1:0] pos_z;
    logic [FACE_W-1:0]        face;
    logic [SHADE_W-1:0]       shade;
    logic                     last_vtx;
  } vertex_t;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [BASE_W-1:0]    cfg_wdata_i   = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic                 kind_i        = 1'b0;
  logic [CELL_W-1:0]    cell_x_i      = '0;
  logic [CELL_W-1:0]    cell_y_i      = '0;
  logic [ALPHA_W-1:0]   texel_alpha_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic [POS_W-1:0]     pos_x_o;
  logic [POS_W-1:0]     pos_y_o;
  logic signed [POSZ_W-1:0] pos_z_o;
  logic [FACE_W-1:0]    face_index_o;
  logic [SHADE_W-1:0]   shade_level_o;
  logic                 last_vertex_o;

  cell_req_t pending_reqs[$];
  vertex_t   vertex_q[$];
  bit [MAP_N-1:0] occ_map [MAP_N];
  logic signed [BASE_W-1:0] height_q = '0;

  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  logic      req_taken     = 1'b0;
  int        error_count   = 0;
  int        cycle_count   = 0;
  cell_req_t drv_req;
  vertex_t   got_vtx;
  vertex_t   want_vtx;

  occupancy_face_culling_mesher_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .cell_x_i      (cell_x_i),
    .cell_y_i      (cell_y_i),
    .texel_alpha_i (texel_alpha_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .pos_z_o       (pos_z_o),
    .face_index_o  (face_index_o),
    .shade_level_o (shade_level_o),
    .last_vertex_o (last_vertex_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // cells off the map read as empty
  function automatic bit occupied(int x, int y);
    if (x < 0 || y < 0 || x >= MAP_N || y >= MAP_N) return 1'b0;
    return occ_map[x][y];
  endfunction

  task automatic mesh_cell(int x, int y);
    int nx, ny, f, v, corner, base;
    logic [2:0] off;
    vertex_t vx;
    if (!occupied(x, y)) return;
    base = height_q;
    for (f = 0; f < 6; f++) begin
      nx = x + int'(f == FACE_EAST) - int'(f == FACE_WEST);
      ny = y + int'(f == FACE_NORTH) - int'(f == FACE_SOUTH);
      if (f < FACE_BOTTOM && occupied(nx, ny)) continue;
      for (v = 0; v < 6; v++) begin
        corner      = TRI_CORNERS[v*2 +: 2];
        off         = BOX_CORNERS[(f*4 + corner)*3 +: 3];
        vx.pos_x    = POS_W'((x + int'(off[2])) * SPAN);
        vx.pos_y    = POS_W'((y + int'(off[1])) * SPAN);
        vx.pos_z    = POSZ_W'(base + BOX_H * int'(off[0]));
        vx.face     = FACE_W'(f);
        case (f)
          FACE_WEST, FACE_EAST:   vx.shade = SHADE_X;
          FACE_SOUTH, FACE_NORTH: vx.shade = SHADE_Y;
          default:                vx.shade = SHADE_Z;
        endcase
        // top is never culled, so it always closes the item
        vx.last_vtx = (f == FACE_TOP) && (v == 5);
        vertex_q.push_back(vx);
      end
    end
  endtask

  // output check first, then prediction for the input transfer at this edge
  always @(posedge clk_i) begin
    req_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_vtx = {pos_x_o, pos_y_o, pos_z_o, face_index_o, shade_level_o, last_vertex_o};
      if (vertex_q.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("unexpected vertex: x=%0d y=%0d z=%0d face=%0d shade=%0d last=%0d",
                   got_vtx.pos_x, got_vtx.pos_y, $signed(got_vtx.pos_z), got_vtx.face,
                   got_vtx.shade, got_vtx.last_vtx);
      end else begin
        want_vtx = vertex_q.pop_front();
        if (got_vtx !== want_vtx) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display({"vertex mismatch: exp x=%0d y=%0d z=%0d face=%0d shade=%0d last=%0d,",
                      " got x=%0d y=%0d z=%0d face=%0d shade=%0d last=%0d"},
                     want_vtx.pos_x, want_vtx.pos_y, $signed(want_vtx.pos_z),
                     want_vtx.face, want_vtx.shade, want_vtx.last_vtx,
                     got_vtx.pos_x, got_vtx.pos_y, $signed(got_vtx.pos_z),
                     got_vtx.face, got_vtx.shade, got_vtx.last_vtx);
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      if (kind_i == KIND_WRITE)
        occ_map[cell_x_i][cell_y_i] = (texel_alpha_i > 8'd1);
      else
        mesh_cell(int'(cell_x_i), int'(cell_y_i));
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      if (!in_valid_i || req_taken) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drv_req = pending_reqs.pop_front();
          in_valid_i    <= 1'b1;
          kind_i        <= drv_req.kind;
          cell_x_i      <= drv_req.cx;
          cell_y_i      <= drv_req.cy;
          texel_alpha_i <= drv_req.alpha;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("occupancy_face_culling_mesher_top_test: errors");
      $finish;
    end
  end

  task automatic queue_req(kind_e k, int x, int y, int a);
    cell_req_t r;
    r.kind  = k;
    r.cx    = CELL_W'(x);
    r.cy    = CELL_W'(y);
    r.alpha = ALPHA_W'(a);
    pending_reqs.push_back(r);
  endtask

  // checked at the rising edge, where queue and valid are stable
  task automatic drain_and_settle();
    @(posedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || vertex_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_base_height(logic [BASE_W-1:0] h);
    @(negedge clk_i);
    cfg_wdata_i <= h;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    height_q     = h;
  endtask

  // mostly clustered in an 8x8 window so neighbors get filled and culled
  task automatic queue_random(int count);
    int wx, wy, x, y, a;
    kind_e k;
    wx = 0;
    wy = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 0) begin
        case ($urandom_range(0, 2))
          0:       wx = 0;
          1:       wx = MAP_N - 8;
          default: wx = $urandom_range(0, MAP_N - 8);
        endcase
        case ($urandom_range(0, 2))
          0:       wy = 0;
          1:       wy = MAP_N - 8;
          default: wy = $urandom_range(0, MAP_N - 8);
        endcase
      end
      if ($urandom_range(0, 99) < 80) begin
        x = wx + $urandom_range(0, 7);
        y = wy + $urandom_range(0, 7);
      end else begin
        x = $urandom_range(0, MAP_N - 1);
        y = $urandom_range(0, MAP_N - 1);
      end
      k = ($urandom_range(0, 99) < 45) ? KIND_EXPAND : KIND_WRITE;
      a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(0, 255);
      queue_req(k, x, y, a);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 12;
    recv_idle_pct = 75;
    write_base_height(16'sh7FFF);

    // lone corner cell, then alpha threshold and east/west culling
    queue_req(KIND_WRITE,  0, 0, 255);
    queue_req(KIND_EXPAND, 0, 0, 0);
    queue_req(KIND_WRITE,  1, 0, 2);
    queue_req(KIND_EXPAND, 0, 0, 0);
    queue_req(KIND_EXPAND, 1, 0, 0);
    queue_req(KIND_WRITE,  1, 0, 1);
    queue_req(KIND_EXPAND, 1, 0, 0);
    queue_req(KIND_EXPAND, 0, 0, 0);
    // far corner, then culled on west and south
    queue_req(KIND_WRITE,  127, 127, 128);
    queue_req(KIND_EXPAND, 127, 127, 0);
    queue_req(KIND_WRITE,  126, 127, 255);
    queue_req(KIND_WRITE,  127, 126, 127);
    queue_req(KIND_EXPAND, 127, 127, 0);
    // enclosed cell keeps only bottom and top
    queue_req(KIND_WRITE,  63, 64, 200);
    queue_req(KIND_WRITE,  65, 64, 200);
    queue_req(KIND_WRITE,  64, 63, 200);
    queue_req(KIND_WRITE,  64, 65, 200);
    queue_req(KIND_WRITE,  64, 64, 200);
    queue_req(KIND_EXPAND, 64, 64, 0);
    queue_req(KIND_EXPAND, 64, 65, 0);
    // cleared cell and a never-written cell give nothing
    queue_req(KIND_WRITE,  64, 64, 0);
    queue_req(KIND_EXPAND, 64, 64, 0);
    queue_req(KIND_EXPAND, 5, 100, 255);
    queue_req(KIND_EXPAND, 63, 64, 0);
    drain_and_settle();

    write_base_height(16'sh8000);
    queue_random(160);
    drain_and_settle();

    send_idle_pct = 75;
    recv_idle_pct = 12;
    write_base_height(BASE_W'($urandom_range(0, 65535)));
    queue_random(160);
    drain_and_settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_base_height(16'sh0000);
    queue_random(160);
    drain_and_settle();

    if (error_count == 0 && vertex_q.size() == 0)
      $display("occupancy_face_culling_mesher_top_test: clean");
    else
      $display("occupancy_face_culling_mesher_top_test: errors");
    $finish;
  end

endmodule
